### rtl/core/stt_pkg.sv
// Shared types, codes and character classes for the Smalltalk-style tokenizer.
package stt_pkg;

  // Default widths of the position counters.
  localparam int OFFSET_BITS_DEF = 32;
  localparam int LINE_BITS_DEF   = 20;
  localparam int COLUMN_BITS_DEF = 16;

  // Fixed field widths.
  localparam int KIND_BITS = 5;
  localparam int ERR_BITS  = 3;
  localparam int LEN_BITS  = 16;

  // Letters in the primitive keyword and the width of the match counter.
  localparam int PRIM_LEN   = 10;
  localparam int MATCH_BITS = 4;

  // Depth of the result queue; a power of two that holds two results per request.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [KIND_BITS-1:0] {
    K_END       = 5'd0,
    K_IDENT     = 5'd1,
    K_KEYWORD   = 5'd2,
    K_INT       = 5'd3,
    K_STRING    = 5'd4,
    K_SYMBOL    = 5'd5,
    K_OPER      = 5'd6,
    K_BAR       = 5'd7,
    K_LPAREN    = 5'd8,
    K_RPAREN    = 5'd9,
    K_LBRACE    = 5'd10,
    K_RBRACE    = 5'd11,
    K_LBRACKET  = 5'd12,
    K_RBRACKET  = 5'd13,
    K_CARET     = 5'd14,
    K_COLON     = 5'd15,
    K_ASSIGN    = 5'd16,
    K_PERIOD    = 5'd17,
    K_PRIMITIVE = 5'd18,
    K_ERROR     = 5'd19
  } tok_kind_t;

  typedef enum logic [ERR_BITS-1:0] {
    E_NONE         = 3'd0,
    E_OPEN_STRING  = 3'd1,
    E_BAD_HASH     = 3'd2,
    E_NO_PRIM_WORD = 3'd3,
    E_NO_ANGLE     = 3'd4,
    E_UNEXPECTED   = 3'd5
  } err_kind_t;

  // Kind and error code of one emitted token.
  typedef struct packed {
    tok_kind_t kind;
    err_kind_t err;
  } tok_ctl_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == " " || c == "\t";
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "/" || c == "=" || c == "<" ||
           c == ">" || c == "%" || c == "&" || c == "|" || c == "~" || c == "," ||
           c == "@";
  endfunction

  // Single-character punctuation tokens; K_END means the byte is not one.
  function automatic tok_kind_t punct_kind(input logic [7:0] c);
    tok_kind_t k;
    case (c)
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "[":     k = K_LBRACKET;
      "]":     k = K_RBRACKET;
      "^":     k = K_CARET;
      ".":     k = K_PERIOD;
      "|":     k = K_BAR;
      default: k = K_END;
    endcase
    return k;
  endfunction

  // Letters of the word "primitive:" by position.
  function automatic logic [7:0] prim_char(input logic [MATCH_BITS-1:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "p";
      4'd1:    ch = "r";
      4'd2:    ch = "i";
      4'd3:    ch = "m";
      4'd4:    ch = "i";
      4'd5:    ch = "t";
      4'd6:    ch = "i";
      4'd7:    ch = "v";
      4'd8:    ch = "e";
      4'd9:    ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

### rtl/core/stt_in_stage.sv
// Input register that holds one source byte request for the scanner.
module stt_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] source_byte,
  input  logic       end_of_input,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_end
);

  logic load;

  // The register refills in the same cycle in which the scanner takes it.
  assign byte_ready = !held_valid || take;
  assign load       = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  // A zero byte closes the source just like the end flag.
  always_ff @(posedge clk) begin
    if (load) begin
      held_byte <= source_byte;
      held_end  <= end_of_input || (source_byte == 8'h00);
    end
  end

endmodule

### rtl/core/stt_token_fmt.sv
// Computes text length and start column of one emitted token.
module stt_token_fmt #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
  input  stt_pkg::tok_ctl_t                  ctl,
  input  logic [OFFSET_BITS-1:0]             start,
  input  logic [OFFSET_BITS-1:0]             offset,
  input  logic [COLUMN_BITS-1:0]             column,
  output logic [stt_pkg::LEN_BITS-1:0]       text_length,
  output logic [COLUMN_BITS-1:0]             column_number
);

  localparam int LB = stt_pkg::LEN_BITS;
  localparam int DW = (OFFSET_BITS > LB) ? OFFSET_BITS : LB;
  localparam int CW = (COLUMN_BITS > LB) ? COLUMN_BITS : LB;

  logic [OFFSET_BITS-1:0] diff;
  logic [DW-1:0]          diff_w;
  logic [LB-1:0]          len_sat;
  logic                   plain;
  logic [CW-1:0]          col_w;
  logic [CW-1:0]          len_w;

  // Length wraps with the offset and saturates at the field maximum.
  assign diff    = offset - start;
  assign diff_w  = DW'(diff);
  assign len_sat = (diff_w > DW'({LB{1'b1}})) ? {LB{1'b1}} : diff_w[LB-1:0];

  // Errors and end tokens carry no text and report the plain column.
  assign plain       = (ctl.kind == stt_pkg::K_END) || (ctl.kind == stt_pkg::K_ERROR);
  assign text_length = plain ? '0 : len_sat;

  // Column where the text began, clamped at zero.
  assign col_w         = CW'(column);
  assign len_w         = CW'(text_length);
  assign column_number = (col_w >= len_w) ? COLUMN_BITS'(col_w - len_w) : '0;

endmodule

### rtl/core/stt_scan.sv
// Scanner state and the two-pass transition for one source byte request.
module stt_scan #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [7:0]                   held_byte,
  input  logic                         held_end,
  output logic [1:0]                   res_count,
  output stt_pkg::tok_ctl_t            slot0_ctl,
  output logic [OFFSET_BITS-1:0]       slot0_start,
  output logic [stt_pkg::LEN_BITS-1:0] slot0_length,
  output logic [COLUMN_BITS-1:0]       slot0_column,
  output stt_pkg::tok_ctl_t            slot1_ctl,
  output logic [OFFSET_BITS-1:0]       slot1_start,
  output logic [stt_pkg::LEN_BITS-1:0] slot1_length,
  output logic [COLUMN_BITS-1:0]       slot1_column,
  output logic [LINE_BITS-1:0]         line_now
);

  localparam int MB = stt_pkg::MATCH_BITS;

  typedef enum logic [13:0] {
    M_IDLE    = 14'b00000000000001,
    M_COMMENT = 14'b00000000000010,
    M_IDENT   = 14'b00000000000100,
    M_NUMBER  = 14'b00000000001000,
    M_COLON   = 14'b00000000010000,
    M_STRING  = 14'b00000000100000,
    M_HASH    = 14'b00000001000000,
    M_SYMSTR  = 14'b00000010000000,
    M_LT      = 14'b00000100000000,
    M_OPER    = 14'b00001000000000,
    M_PWORD   = 14'b00010000000000,
    M_PWS1    = 14'b00100000000000,
    M_PDIGITS = 14'b01000000000000,
    M_PWS2    = 14'b10000000000000
  } scan_mode_t;

  scan_mode_t             scan_mode;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] token_start;
  logic [LINE_BITS-1:0]   line_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic [MB-1:0]          match_index;

  logic [OFFSET_BITS-1:0] off_inc;
  logic [COLUMN_BITS-1:0] col_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [7:0]             c;

  // First pass: the pending token looks at the byte.
  logic                   p1_consume;
  logic                   p1_newline;
  logic                   a_valid;
  stt_pkg::tok_ctl_t      a_ctl;
  logic                   a_after;
  logic [OFFSET_BITS-1:0] ts1;
  scan_mode_t             mode1;
  logic [MB-1:0]          match1;
  logic                   rescan;

  // Second pass: the byte starts something new from idle.
  logic                   p2_consume;
  logic                   p2_newline;
  logic                   b_valid;
  stt_pkg::tok_ctl_t      b_ctl;
  logic [OFFSET_BITS-1:0] ts2;
  scan_mode_t             mode2;
  stt_pkg::tok_kind_t     pk;

  // Merged results of both passes.
  logic                   consume;
  logic                   newline;
  scan_mode_t             scan_mode_next;
  logic [OFFSET_BITS-1:0] token_start_next;
  logic [MB-1:0]          match_index_next;

  logic                   fb_valid;
  stt_pkg::tok_ctl_t      fb_ctl;
  logic [OFFSET_BITS-1:0] fb_start;
  logic [OFFSET_BITS-1:0] fb_off;
  logic [COLUMN_BITS-1:0] fb_col;
  logic [OFFSET_BITS-1:0] fa_off;
  logic [COLUMN_BITS-1:0] fa_col;
  logic [stt_pkg::LEN_BITS-1:0] a_len;
  logic [COLUMN_BITS-1:0]       a_colnum;
  logic [stt_pkg::LEN_BITS-1:0] b_len;
  logic [COLUMN_BITS-1:0]       b_colnum;

  assign c = held_byte;

  // Counter increments; offset wraps, line and column saturate.
  assign off_inc  = byte_offset + OFFSET_BITS'(1);
  assign col_inc  = (column_count == '1) ? column_count : column_count + 1'b1;
  assign line_inc = (line_count == '1) ? line_count : line_count + 1'b1;

  // Pending token: extend it, close it, or close it and hand the byte to idle.
  always_comb begin
    p1_consume = 1'b0;
    p1_newline = 1'b0;
    a_valid    = 1'b0;
    a_ctl      = '{kind: stt_pkg::K_END, err: stt_pkg::E_NONE};
    a_after    = 1'b0;
    ts1        = token_start;
    mode1      = scan_mode;
    match1     = match_index;
    rescan     = 1'b0;
    if (held_end) begin
      // End mark flushes whatever is open.
      mode1  = M_IDLE;
      match1 = '0;
      unique case (scan_mode)
        M_IDLE, M_COMMENT: begin
        end
        M_IDENT: begin
          a_valid = 1'b1; a_ctl.kind = stt_pkg::K_IDENT;
        end
        M_NUMBER: begin
          a_valid = 1'b1; a_ctl.kind = stt_pkg::K_INT;
        end
        M_COLON: begin
          a_valid = 1'b1; a_ctl.kind = stt_pkg::K_COLON;
        end
        M_STRING: begin
          a_valid = 1'b1; a_ctl.kind = stt_pkg::K_STRING;
        end
        M_HASH: begin
          a_valid = 1'b1; a_ctl = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_BAD_HASH};
        end
        M_SYMSTR: begin
          a_valid = 1'b1; a_ctl.kind = stt_pkg::K_SYMBOL;
        end
        M_LT, M_OPER: begin
          a_valid = 1'b1; a_ctl.kind = stt_pkg::K_OPER;
        end
        M_PWORD: begin
          a_valid = 1'b1;
          a_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_NO_PRIM_WORD};
        end
        M_PWS1: begin
          ts1     = byte_offset;
          a_valid = 1'b1;
          a_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_NO_ANGLE};
        end
        M_PDIGITS, M_PWS2: begin
          a_valid = 1'b1;
          a_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_NO_ANGLE};
        end
        default: begin
        end
      endcase
    end else begin
      unique case (scan_mode)
        M_IDLE: rescan = 1'b1;
        M_COMMENT: begin
          if (c == "\"") begin
            p1_consume = 1'b1; mode1 = M_IDLE;
          end else if (c == "\n") begin
            p1_newline = 1'b1;
          end else begin
            p1_consume = 1'b1;
          end
        end
        M_IDENT: begin
          if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)) begin
            p1_consume = 1'b1;
          end else if (c == ":") begin
            p1_consume = 1'b1; mode1 = M_IDLE;
            a_valid = 1'b1; a_after = 1'b1; a_ctl.kind = stt_pkg::K_KEYWORD;
          end else begin
            a_valid = 1'b1; a_ctl.kind = stt_pkg::K_IDENT; rescan = 1'b1;
          end
        end
        M_NUMBER: begin
          if (stt_pkg::is_digit(c)) begin
            p1_consume = 1'b1;
          end else begin
            a_valid = 1'b1; a_ctl.kind = stt_pkg::K_INT; rescan = 1'b1;
          end
        end
        M_COLON: begin
          if (c == "=") begin
            p1_consume = 1'b1; mode1 = M_IDLE;
            a_valid = 1'b1; a_after = 1'b1; a_ctl.kind = stt_pkg::K_ASSIGN;
          end else begin
            a_valid = 1'b1; a_ctl.kind = stt_pkg::K_COLON; rescan = 1'b1;
          end
        end
        M_STRING: begin
          if (c == "'") begin
            a_valid = 1'b1; a_ctl.kind = stt_pkg::K_STRING;
            p1_consume = 1'b1; mode1 = M_IDLE;
          end else if (c == "\n") begin
            a_valid = 1'b1;
            a_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_OPEN_STRING};
            rescan  = 1'b1;
          end else begin
            p1_consume = 1'b1;
          end
        end
        M_HASH: begin
          if (stt_pkg::is_letter(c)) begin
            ts1 = byte_offset; p1_consume = 1'b1; mode1 = M_IDENT;
          end else if (c == "'") begin
            p1_consume = 1'b1; ts1 = off_inc; mode1 = M_SYMSTR;
          end else begin
            a_valid = 1'b1;
            a_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_BAD_HASH};
            rescan  = 1'b1;
          end
        end
        M_SYMSTR: begin
          // Newlines inside a quoted symbol do not count lines.
          p1_consume = 1'b1;
          if (c == "'") begin
            a_valid = 1'b1; a_ctl.kind = stt_pkg::K_SYMBOL; mode1 = M_IDLE;
          end
        end
        M_LT, M_OPER: begin
          if (scan_mode == M_LT && c == "p") begin
            p1_consume = 1'b1; match1 = MB'(1); mode1 = M_PWORD;
          end else if (stt_pkg::is_oper(c)) begin
            p1_consume = 1'b1; mode1 = M_OPER;
          end else begin
            a_valid = 1'b1; a_ctl.kind = stt_pkg::K_OPER; rescan = 1'b1;
          end
        end
        M_PWORD: begin
          if (c == stt_pkg::prim_char(match_index)) begin
            p1_consume = 1'b1;
            match1     = match_index + 1'b1;
            if (match1 == MB'(stt_pkg::PRIM_LEN)) begin
              mode1 = M_PWS1;
            end
          end else begin
            a_valid = 1'b1;
            a_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_NO_PRIM_WORD};
            rescan  = 1'b1;
          end
        end
        M_PWS1, M_PDIGITS, M_PWS2: begin
          // Blanks, then digits, then blanks and the closing angle.
          if (scan_mode == M_PWS1 && stt_pkg::is_blank(c)) begin
            p1_consume = 1'b1;
          end else if (scan_mode != M_PWS2 && stt_pkg::is_digit(c)) begin
            p1_consume = 1'b1; mode1 = M_PDIGITS;
          end else if (stt_pkg::is_blank(c)) begin
            p1_consume = 1'b1; mode1 = M_PWS2;
          end else if (c == ">") begin
            p1_consume = 1'b1; mode1 = M_IDLE;
            a_valid = 1'b1; a_after = 1'b1; a_ctl.kind = stt_pkg::K_PRIMITIVE;
          end else begin
            a_valid = 1'b1;
            a_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_NO_ANGLE};
            rescan  = 1'b1;
          end
          if (scan_mode == M_PWS1 && !stt_pkg::is_blank(c)) begin
            ts1 = byte_offset;
          end
        end
        default: rescan = 1'b1;
      endcase
    end
  end

  assign pk = stt_pkg::punct_kind(c);

  // Idle scan: skip blanks, open comments, or start a new token.
  always_comb begin
    p2_consume = 1'b0;
    p2_newline = 1'b0;
    b_valid    = 1'b0;
    b_ctl      = '{kind: stt_pkg::K_END, err: stt_pkg::E_NONE};
    ts2        = ts1;
    mode2      = M_IDLE;
    if (c == " " || c == "\r" || c == "\t") begin
      p2_consume = 1'b1;
    end else if (c == "\n") begin
      p2_newline = 1'b1;
    end else if (c == "\"") begin
      p2_consume = 1'b1; mode2 = M_COMMENT;
    end else begin
      ts2        = byte_offset;
      p2_consume = 1'b1;
      if (pk != stt_pkg::K_END) begin
        b_valid = 1'b1; b_ctl.kind = pk;
      end else if (stt_pkg::is_letter(c)) begin
        mode2 = M_IDENT;
      end else if (stt_pkg::is_digit(c)) begin
        mode2 = M_NUMBER;
      end else if (c == ":") begin
        mode2 = M_COLON;
      end else if (c == "'") begin
        ts2 = off_inc; mode2 = M_STRING;
      end else if (c == "#") begin
        mode2 = M_HASH;
      end else if (c == "<") begin
        mode2 = M_LT;
      end else if (stt_pkg::is_oper(c)) begin
        mode2 = M_OPER;
      end else begin
        b_valid = 1'b1;
        b_ctl   = '{kind: stt_pkg::K_ERROR, err: stt_pkg::E_UNEXPECTED};
      end
    end
  end

  // Merge the two passes; only one of them ever consumes the byte.
  always_comb begin
    consume          = 1'b0;
    newline          = 1'b0;
    scan_mode_next   = mode1;
    token_start_next = ts1;
    match_index_next = match1;
    if (held_end) begin
      token_start_next = byte_offset;
    end else if (rescan) begin
      consume          = p2_consume;
      newline          = p2_newline;
      scan_mode_next   = mode2;
      token_start_next = ts2;
    end else begin
      consume = p1_consume;
      newline = p1_newline;
    end
  end

  // Second token: the end token on an end mark, else what idle emits.
  assign fb_valid = held_end || (rescan && b_valid);
  assign fb_ctl   = held_end ? '{kind: stt_pkg::K_END, err: stt_pkg::E_NONE} : b_ctl;
  assign fb_start = held_end ? byte_offset : ts2;
  assign fb_off   = held_end ? byte_offset : off_inc;
  assign fb_col   = held_end ? column_count : col_inc;

  // First token sees the counters before or after the byte is consumed.
  assign fa_off = a_after ? off_inc : byte_offset;
  assign fa_col = a_after ? col_inc : column_count;

  stt_token_fmt #(
    .OFFSET_BITS(OFFSET_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_fmt_first (
    .ctl          (a_ctl),
    .start        (ts1),
    .offset       (fa_off),
    .column       (fa_col),
    .text_length  (a_len),
    .column_number(a_colnum)
  );

  stt_token_fmt #(
    .OFFSET_BITS(OFFSET_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_fmt_second (
    .ctl          (fb_ctl),
    .start        (fb_start),
    .offset       (fb_off),
    .column       (fb_col),
    .text_length  (b_len),
    .column_number(b_colnum)
  );

  // Pack the emitted tokens into consecutive queue slots.
  assign res_count    = {1'b0, a_valid} + {1'b0, fb_valid};
  assign slot0_ctl    = a_valid ? a_ctl : fb_ctl;
  assign slot0_start  = a_valid ? ts1 : fb_start;
  assign slot0_length = a_valid ? a_len : b_len;
  assign slot0_column = a_valid ? a_colnum : b_colnum;
  assign slot1_ctl    = fb_ctl;
  assign slot1_start  = fb_start;
  assign slot1_length = b_len;
  assign slot1_column = b_colnum;
  assign line_now     = line_count;

  // Scanner registers advance once per taken request.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode    <= M_IDLE;
      byte_offset  <= '0;
      token_start  <= '0;
      line_count   <= LINE_BITS'(1);
      column_count <= '0;
      match_index  <= '0;
    end else if (take) begin
      scan_mode   <= scan_mode_next;
      token_start <= token_start_next;
      match_index <= match_index_next;
      if (consume || newline) begin
        byte_offset <= off_inc;
      end
      if (newline) begin
        line_count   <= line_inc;
        column_count <= COLUMN_BITS'(1);
      end else if (consume) begin
        column_count <= col_inc;
      end
    end
  end

endmodule

### rtl/core/stt_result_fifo.sv
// Result queue that takes up to two tokens per cycle and delivers one per cycle when popped.
module stt_result_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_count,
  input  logic [WIDTH-1:0] push_data0,
  input  logic [WIDTH-1:0] push_data1,
  output logic             room,
  input  logic             pop,
  output logic             out_valid,
  output logic [WIDTH-1:0] out_data
);

  localparam int DEPTH = stt_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  // Room for a full request of two tokens.
  assign room      = count <= CW'(DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_data0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push_data1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push_count) - CW'(pop);
    end
  end

endmodule

### rtl/core/smalltalk_style_tokenizer.sv
// Top level of the Smalltalk-style tokenizer: input register, scanner, result queue.
//
//   channel   handshake                  payload
//   source    byte_valid / byte_ready    source_byte, end_of_input
//   token     token_valid / token_ready  token_kind, error_kind, start_offset,
//                                        text_length, line_number, column_number,
//                                        last_of_run
//
// One source byte request is taken per cycle while the queue has room. It is
// held in the input register, then the scanner decides it combinationally and
// writes zero, one or two tokens into a four-entry queue. A request that gives
// two tokens needs two pops on the token side, so the token port sets the
// sustained rate. The scanner holds its request while fewer than two queue
// entries are free. Reset returns the scanner to idle at offset 0, line 1,
// column 0 and empties the queue.
module smalltalk_style_tokenizer #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [7:0]                    source_byte,
  input  logic                          end_of_input,
  output logic                          token_valid,
  input  logic                          token_ready,
  output logic [stt_pkg::KIND_BITS-1:0] token_kind,
  output logic [stt_pkg::ERR_BITS-1:0]  error_kind,
  output logic [OFFSET_BITS-1:0]        start_offset,
  output logic [stt_pkg::LEN_BITS-1:0]  text_length,
  output logic [LINE_BITS-1:0]          line_number,
  output logic [COLUMN_BITS-1:0]        column_number,
  output logic                          last_of_run
);

  localparam int W = stt_pkg::KIND_BITS + stt_pkg::ERR_BITS + OFFSET_BITS +
                     stt_pkg::LEN_BITS + LINE_BITS + COLUMN_BITS + 1;

  logic                         held_valid;
  logic [7:0]                   held_byte;
  logic                         held_end;
  logic                         take;
  logic                         room;
  logic [1:0]                   res_count;
  logic [1:0]                   push_count;
  stt_pkg::tok_ctl_t            slot0_ctl;
  logic [OFFSET_BITS-1:0]       slot0_start;
  logic [stt_pkg::LEN_BITS-1:0] slot0_length;
  logic [COLUMN_BITS-1:0]       slot0_column;
  stt_pkg::tok_ctl_t            slot1_ctl;
  logic [OFFSET_BITS-1:0]       slot1_start;
  logic [stt_pkg::LEN_BITS-1:0] slot1_length;
  logic [COLUMN_BITS-1:0]       slot1_column;
  logic [LINE_BITS-1:0]         line_now;
  logic [W-1:0]                 push_data0;
  logic [W-1:0]                 push_data1;
  logic [W-1:0]                 out_data;

  stt_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .source_byte (source_byte),
    .end_of_input(end_of_input),
    .take        (take),
    .held_valid  (held_valid),
    .held_byte   (held_byte),
    .held_end    (held_end)
  );

  // The scanner takes the held request once the queue can absorb two tokens.
  assign take       = held_valid && room;
  assign push_count = take ? res_count : 2'd0;

  stt_scan #(
    .OFFSET_BITS(OFFSET_BITS),
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .held_byte   (held_byte),
    .held_end    (held_end),
    .res_count   (res_count),
    .slot0_ctl   (slot0_ctl),
    .slot0_start (slot0_start),
    .slot0_length(slot0_length),
    .slot0_column(slot0_column),
    .slot1_ctl   (slot1_ctl),
    .slot1_start (slot1_start),
    .slot1_length(slot1_length),
    .slot1_column(slot1_column),
    .line_now    (line_now)
  );

  // The last token of a request carries the run mark.
  assign push_data0 = {slot0_ctl, slot0_start, slot0_length, line_now, slot0_column,
                       res_count == 2'd1};
  assign push_data1 = {slot1_ctl, slot1_start, slot1_length, line_now, slot1_column, 1'b1};

  stt_result_fifo #(
    .WIDTH(W)
  ) u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(push_count),
    .push_data0(push_data0),
    .push_data1(push_data1),
    .room      (room),
    .pop       (token_valid && token_ready),
    .out_valid (token_valid),
    .out_data  (out_data)
  );

  assign {token_kind, error_kind, start_offset, text_length, line_number, column_number,
          last_of_run} = out_data;

endmodule

### rtl/core/stt_port_checker.sv
// Port-level checks on the tokenizer's token channel, bound to the top level.
module stt_port_checker #(
  parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS = stt_pkg::COLUMN_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          token_valid,
  input logic                          token_ready,
  input logic [stt_pkg::KIND_BITS-1:0] token_kind,
  input logic [stt_pkg::ERR_BITS-1:0]  error_kind,
  input logic [OFFSET_BITS-1:0]        start_offset,
  input logic [stt_pkg::LEN_BITS-1:0]  text_length,
  input logic [LINE_BITS-1:0]          line_number,
  input logic [COLUMN_BITS-1:0]        column_number,
  input logic                          last_of_run
);

  // A stalled token holds its kind, start offset, column and run mark.
  a_token_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token_kind) &&
    $stable(start_offset) && $stable(column_number) && $stable(last_of_run))
    else $error("token changed while stalled");

  // Only error tokens carry an error code.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind != stt_pkg::K_ERROR |-> error_kind == stt_pkg::E_NONE)
    else $error("error code on a non-error token");

  // Errors and end tokens have no text.
  a_no_text: assert property (@(posedge clk) disable iff (rst)
    token_valid && (token_kind == stt_pkg::K_ERROR || token_kind == stt_pkg::K_END)
    |-> text_length == '0)
    else $error("text length on an error or end token");

  // The end token always closes its request.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_kind == stt_pkg::K_END |-> last_of_run)
    else $error("end token not marked last");

  // Lines count from one.
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> line_number != '0)
    else $error("line number zero");

endmodule

bind smalltalk_style_tokenizer stt_port_checker #(
  .OFFSET_BITS(OFFSET_BITS),
  .LINE_BITS  (LINE_BITS),
  .COLUMN_BITS(COLUMN_BITS)
) u_port_checker (
  .clk          (clk),
  .rst          (rst),
  .token_valid  (token_valid),
  .token_ready  (token_ready),
  .token_kind   (token_kind),
  .error_kind   (error_kind),
  .start_offset (start_offset),
  .text_length  (text_length),
  .line_number  (line_number),
  .column_number(column_number),
  .last_of_run  (last_of_run)
);

### dv/tb_smalltalk_style_tokenizer.sv
// Self-checking testbench for the Smalltalk-style tokenizer with a built-in token predictor.
`timescale 1ns / 1ps

module tb_smalltalk_style_tokenizer;
  import stt_pkg::*;

  localparam int OB = OFFSET_BITS_DEF;
  localparam int LB = LINE_BITS_DEF;
  localparam int CB = COLUMN_BITS_DEF;
  localparam logic [LB-1:0] LINE_MAX = {LB{1'b1}};
  localparam logic [CB-1:0] COL_MAX = {CB{1'b1}};
  localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 420;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [8*13-1:0] OPER_CHARS = "+-*/=<>%&|~,@";
  localparam logic [8*10-1:0] PRIM_WORD = "primitive:";
  localparam logic [8*9-1:0] PUNCT_CHARS = "()[]{}^.|";

  // Scanner states of the predictor.
  typedef enum logic [3:0] {
    SM_IDLE, SM_COMMENT, SM_IDENT, SM_NUMBER, SM_COLON, SM_STRING, SM_HASH,
    SM_SYMSTR, SM_LT, SM_OPER, SM_PWORD, SM_PWS1, SM_PDIGITS, SM_PWS2
  } scan_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } src_req_t;

  typedef struct {
    tok_kind_t           kind;
    err_kind_t           err;
    logic [OB-1:0]       start;
    logic [LEN_BITS-1:0] len;
    logic [LB-1:0]       line;
    logic [CB-1:0]       col;
    logic                last;
  } token_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic [7:0] source_byte = 8'h00;
  logic end_of_input = 1'b0;
  logic token_ready = 1'b0;
  logic byte_ready;
  logic token_valid;
  logic [KIND_BITS-1:0] token_kind;
  logic [ERR_BITS-1:0] error_kind;
  logic [OB-1:0] start_offset;
  logic [LEN_BITS-1:0] text_length;
  logic [LB-1:0] line_number;
  logic [CB-1:0] column_number;
  logic last_of_run;

  src_req_t pending_bytes[$];
  token_rec_t due_tokens[$];
  int queued_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  // Predictor state.
  scan_state_t scan_st = SM_IDLE;
  logic [OB-1:0] pos = '0;
  logic [OB-1:0] tok_start = '0;
  logic [LB-1:0] line_cnt = 1;
  logic [CB-1:0] col_cnt = '0;
  logic [MATCH_BITS-1:0] prim_idx = '0;

  smalltalk_style_tokenizer dut (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_ready(byte_ready),
    .source_byte(source_byte),
    .end_of_input(end_of_input),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token_kind(token_kind),
    .error_kind(error_kind),
    .start_offset(start_offset),
    .text_length(text_length),
    .line_number(line_number),
    .column_number(column_number),
    .last_of_run(last_of_run)
  );

  always #1 clk = ~clk;

  // Character classes.
  function automatic bit letter_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank_byte(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic bit oper_byte(logic [7:0] c);
    int i;
    for (i = 0; i < 13; i++)
      if (OPER_CHARS[8*i +: 8] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] prim_letter(int idx);
    return PRIM_WORD[8*(9-idx) +: 8];
  endfunction

  // Position bookkeeping for one consumed byte and for a counted newline.
  function automatic void consume();
    pos = pos + 1'b1;
    if (col_cnt != COL_MAX) col_cnt = col_cnt + 1'b1;
  endfunction

  function automatic void new_line();
    if (line_cnt != LINE_MAX) line_cnt = line_cnt + 1'b1;
    col_cnt = '0;
    consume();
  endfunction

  function automatic void push_token(tok_kind_t k, err_kind_t e, logic [OB-1:0] s,
                                     logic [LEN_BITS-1:0] l, logic [CB-1:0] c);
    token_rec_t t;
    t.kind = k;
    t.err = e;
    t.start = s;
    t.len = l;
    t.line = line_cnt;
    t.col = c;
    t.last = 1'b0;
    due_tokens.push_back(t);
  endfunction

  // A text token spans from the token start to the current offset.
  function automatic void emit_text(tok_kind_t k);
    logic [OB-1:0] span;
    logic [LEN_BITS-1:0] l;
    logic [CB-1:0] c;
    span = pos - tok_start;
    l = (span > OB'(LEN_MAX)) ? LEN_MAX : span[LEN_BITS-1:0];
    c = (col_cnt >= l) ? col_cnt - l : '0;
    push_token(k, E_NONE, tok_start, l, c);
  endfunction

  function automatic void emit_error(err_kind_t e);
    push_token(K_ERROR, e, tok_start, '0, col_cnt);
  endfunction

  // A byte seen between tokens.
  function automatic void idle_char(logic [7:0] c);
    tok_kind_t k;
    k = K_END;
    case (c)
      CH_SPACE, CH_CR, CH_TAB: begin
        consume();
        return;
      end
      CH_LF: begin
        new_line();
        return;
      end
      CH_DQUOTE: begin
        consume();
        scan_st = SM_COMMENT;
        return;
      end
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "[": k = K_LBRACKET;
      "]": k = K_RBRACKET;
      "^": k = K_CARET;
      ".": k = K_PERIOD;
      "|": k = K_BAR;
      default: k = K_END;
    endcase
    tok_start = pos;
    consume();
    if (k != K_END) emit_text(k);
    else if (letter_byte(c)) scan_st = SM_IDENT;
    else if (digit_byte(c)) scan_st = SM_NUMBER;
    else if (c == ":") scan_st = SM_COLON;
    else if (c == CH_QUOTE) begin
      tok_start = pos;
      scan_st = SM_STRING;
    end
    else if (c == "#") scan_st = SM_HASH;
    else if (c == "<") scan_st = SM_LT;
    else if (oper_byte(c)) scan_st = SM_OPER;
    else emit_error(E_UNEXPECTED);
  endfunction

  // One source byte; a byte that ends a token is scanned again from idle.
  function automatic void scan_char(logic [7:0] c);
    bit done;
    done = 1'b0;
    while (!done) begin
      done = 1'b1;
      case (scan_st)
        SM_IDLE: idle_char(c);
        SM_COMMENT: begin
          if (c == CH_DQUOTE) begin
            consume();
            scan_st = SM_IDLE;
          end
          else if (c == CH_LF) new_line();
          else consume();
        end
        SM_IDENT: begin
          if (letter_byte(c) || digit_byte(c)) consume();
          else if (c == ":") begin
            consume();
            scan_st = SM_IDLE;
            emit_text(K_KEYWORD);
          end
          else begin
            emit_text(K_IDENT);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
        end
        SM_NUMBER: begin
          if (digit_byte(c)) consume();
          else begin
            emit_text(K_INT);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
        end
        SM_COLON: begin
          if (c == "=") begin
            consume();
            scan_st = SM_IDLE;
            emit_text(K_ASSIGN);
          end
          else begin
            emit_text(K_COLON);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
        end
        SM_STRING: begin
          if (c == CH_QUOTE) begin
            emit_text(K_STRING);
            consume();
            scan_st = SM_IDLE;
          end
          else if (c == CH_LF) begin
            emit_error(E_OPEN_STRING);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
          else consume();
        end
        SM_HASH: begin
          if (letter_byte(c)) begin
            tok_start = pos;
            consume();
            scan_st = SM_IDENT;
          end
          else if (c == CH_QUOTE) begin
            consume();
            tok_start = pos;
            scan_st = SM_SYMSTR;
          end
          else begin
            emit_error(E_BAD_HASH);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
        end
        SM_SYMSTR: begin
          if (c == CH_QUOTE) begin
            emit_text(K_SYMBOL);
            consume();
            scan_st = SM_IDLE;
          end
          else consume();
        end
        SM_LT: begin
          if (c == "p") begin
            consume();
            prim_idx = 1;
            scan_st = SM_PWORD;
          end
          else begin
            scan_st = SM_OPER;
            done = 1'b0;
          end
        end
        SM_OPER: begin
          if (oper_byte(c)) consume();
          else begin
            emit_text(K_OPER);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
        end
        SM_PWORD: begin
          if (prim_idx < PRIM_LEN && c == prim_letter(prim_idx)) begin
            consume();
            prim_idx = prim_idx + 1'b1;
            if (prim_idx >= PRIM_LEN) scan_st = SM_PWS1;
          end
          else begin
            emit_error(E_NO_PRIM_WORD);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
        end
        SM_PWS1: begin
          if (blank_byte(c)) consume();
          else begin
            tok_start = pos;
            scan_st = SM_PDIGITS;
            done = 1'b0;
          end
        end
        SM_PDIGITS: begin
          if (digit_byte(c)) consume();
          else begin
            scan_st = SM_PWS2;
            done = 1'b0;
          end
        end
        SM_PWS2: begin
          if (blank_byte(c)) consume();
          else if (c == ">") begin
            consume();
            scan_st = SM_IDLE;
            emit_text(K_PRIMITIVE);
          end
          else begin
            emit_error(E_NO_ANGLE);
            scan_st = SM_IDLE;
            done = 1'b0;
          end
        end
        default: begin
          scan_st = SM_IDLE;
          done = 1'b0;
        end
      endcase
    end
  endfunction

  // An end mark flushes the pending token and adds the end token.
  function automatic void flush_at_end();
    case (scan_st)
      SM_IDENT: emit_text(K_IDENT);
      SM_NUMBER: emit_text(K_INT);
      SM_COLON: emit_text(K_COLON);
      SM_STRING: emit_text(K_STRING);
      SM_HASH: emit_error(E_BAD_HASH);
      SM_SYMSTR: emit_text(K_SYMBOL);
      SM_LT, SM_OPER: emit_text(K_OPER);
      SM_PWORD: emit_error(E_NO_PRIM_WORD);
      SM_PWS1: begin
        tok_start = pos;
        emit_error(E_NO_ANGLE);
      end
      SM_PDIGITS, SM_PWS2: emit_error(E_NO_ANGLE);
      default: ;
    endcase
    tok_start = pos;
    push_token(K_END, E_NONE, pos, '0, col_cnt);
    scan_st = SM_IDLE;
    prim_idx = '0;
  endfunction

  // Works out the tokens of one accepted request and marks the last of them.
  function automatic void tokenize_request(logic [7:0] c, logic eoi);
    int before_cnt;
    token_rec_t t;
    before_cnt = due_tokens.size();
    if (eoi || c == 8'h00) flush_at_end();
    else scan_char(c);
    if (due_tokens.size() > before_cnt) begin
      t = due_tokens.pop_back();
      t.last = 1'b1;
      due_tokens.push_back(t);
    end
  endfunction

  // Stimulus builders.
  function automatic void put_char(logic [7:0] c);
    src_req_t r;
    r.data = c;
    r.eoi = 1'b0;
    pending_bytes.push_back(r);
    queued_count++;
  endfunction

  function automatic void put_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  function automatic void put_end_mark();
    src_req_t r;
    if ($urandom_range(0, 1) == 0) begin
      r.data = 8'($urandom_range(0, 255));
      r.eoi = 1'b1;
    end
    else begin
      r.data = 8'h00;
      r.eoi = 1'($urandom_range(0, 1));
    end
    pending_bytes.push_back(r);
    queued_count++;
  endfunction

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return CH_LF;
    if (r < 9) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic void put_word(bit keyword);
    int n, i;
    n = $urandom_range(1, 8);
    put_char(word_char(1'b1));
    for (i = 1; i < n; i++) put_char(word_char(1'b0));
    if (keyword) put_char(":");
  endfunction

  function automatic void put_body(logic [7:0] closer, int close_pct);
    int n, i;
    n = $urandom_range(0, 8);
    for (i = 0; i < n; i++) put_char(text_char());
    if ($urandom_range(0, 99) < close_pct) put_char(closer);
  endfunction

  // Primitive markers, sometimes with a broken word or a missing closing angle.
  function automatic void put_primitive();
    int cut, i, n;
    put_char("<");
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : 10;
    for (i = 0; i < cut; i++) put_char(prim_letter(i));
    if (cut < 10) begin
      put_char(word_char(1'b0));
      return;
    end
    n = $urandom_range(0, 2);
    for (i = 0; i < n; i++) put_char(blank_char());
    n = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
    for (i = 0; i < n; i++) put_char(8'("0" + $urandom_range(0, 9)));
    n = $urandom_range(0, 2);
    for (i = 0; i < n; i++) put_char(blank_char());
    if ($urandom_range(0, 99) < 85) put_char(">");
    else put_char(word_char(1'b0));
  endfunction

  // One random source fragment, mostly well-formed, followed by an optional separator.
  function automatic void add_fragment();
    int pick, n, i;
    pick = $urandom_range(0, 99);
    if (pick < 14) put_word($urandom_range(0, 9) < 3);
    else if (pick < 22) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) put_char(8'("0" + $urandom_range(0, 9)));
    end
    else if (pick < 30) begin
      put_char(CH_QUOTE);
      put_body(CH_QUOTE, 85);
    end
    else if (pick < 36) begin
      put_char(CH_DQUOTE);
      put_body(CH_DQUOTE, 90);
    end
    else if (pick < 44) begin
      put_char("#");
      case ($urandom_range(0, 2))
        0: put_word($urandom_range(0, 9) < 3);
        1: begin
          put_char(CH_QUOTE);
          put_body(CH_QUOTE, 80);
        end
        default: put_char(8'($urandom_range(1, 255)));
      endcase
    end
    else if (pick < 54) put_primitive();
    else if (pick < 62) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) put_char(OPER_CHARS[8*$urandom_range(0, 12) +: 8]);
    end
    else if (pick < 74) begin
      n = $urandom_range(0, 10);
      if (n < 9) put_char(PUNCT_CHARS[8*n +: 8]);
      else if (n == 9) put_char(":");
      else put_text(":=");
    end
    else if (pick < 84) begin
      case ($urandom_range(0, 3))
        0: put_char(CH_SPACE);
        1: put_char(CH_TAB);
        2: put_char(CH_CR);
        default: put_char(CH_LF);
      endcase
    end
    else if (pick < 92) put_char(8'($urandom_range(1, 255)));
    else put_end_mark();
    if ($urandom_range(0, 9) < 6) put_char($urandom_range(0, 4) == 0 ? CH_LF : blank_char());
  endfunction

  // Sender: offers the next pending request and predicts each accepted one.
  always @(posedge clk) begin : source_driver
    src_req_t nxt;
    bit taken;
    if (rst) begin
      byte_valid <= 1'b0;
      source_byte <= 8'h00;
      end_of_input <= 1'b0;
    end
    else begin
      taken = byte_valid && byte_ready;
      if (taken) tokenize_request(source_byte, end_of_input);
      if (!byte_valid || taken) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          nxt = pending_bytes.pop_front();
          byte_valid <= 1'b1;
          source_byte <= nxt.data;
          end_of_input <= nxt.eoi;
        end
        else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted token against the oldest expected one.
  always @(posedge clk) begin : token_monitor
    token_rec_t t;
    if (rst) begin
      token_ready <= 1'b0;
    end
    else begin
      if (token_valid && token_ready) begin
        if (due_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected token: kind %0d err %0d start %0d len %0d line %0d col %0d",
                     token_kind, error_kind, start_offset, text_length, line_number,
                     column_number);
        end
        else begin
          t = due_tokens.pop_front();
          if (token_kind != t.kind || error_kind != t.err || start_offset != t.start ||
              text_length != t.len || line_number != t.line || column_number != t.col ||
              last_of_run != t.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"token mismatch: expected kind %0d err %0d start %0d len %0d ",
                        "line %0d col %0d last %0d; got kind %0d err %0d start %0d ",
                        "len %0d line %0d col %0d last %0d"},
                       t.kind, t.err, t.start, t.len, t.line, t.col, t.last,
                       token_kind, error_kind, start_offset, text_length, line_number,
                       column_number, last_of_run);
          end
        end
      end
      // A requested long hold-off is counted here, cycle by cycle.
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        token_ready <= 1'b0;
      end
      else begin
        token_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_valid && byte_ready) || (token_valid && token_ready)) begin
        idle_cycles <= 0;
      end
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d quiet cycles", idle_cycles);
        $display("smalltalk_style_tokenizer regression: fail");
        $finish;
      end
      else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Sequencer: reset, directed requests, then four random phases with different sender gaps and receiver stalls.
  initial begin : sequencer
    int phase, first_item;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Keyword, integer, assign, quoted symbol, primitive, stray high byte, end marks.
    put_text("ab: 7:=#'q'<primitive:9>");
    put_char(8'hFF);
    put_char(8'h00);
    put_end_mark();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 71; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 71; end
        default: begin send_gap_pct = 28; recv_stall_pct = 28; end
      endcase
      first_item = queued_count;
      while (queued_count - first_item < PHASE_ITEMS) add_fragment();
      // The receiver holds off while the sender keeps offering, so the input stalls.
      if (phase == 0) hold_asked++;
      while (pending_bytes.size() != 0) @(negedge clk);
      // The sender pauses until every expected token has come back.
      if (phase == 1)
        while (byte_valid || due_tokens.size() != 0) @(negedge clk);
    end

    while (byte_valid || due_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && due_tokens.size() == 0) begin
      $display("smalltalk_style_tokenizer regression: pass");
    end
    else begin
      $display("%0d mismatches, %0d tokens outstanding", mismatch_count, due_tokens.size());
      $display("smalltalk_style_tokenizer regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/stt_pkg.sv
rtl/core/stt_in_stage.sv
rtl/core/stt_token_fmt.sv
rtl/core/stt_scan.sv
rtl/core/stt_result_fifo.sv
rtl/core/smalltalk_style_tokenizer.sv
rtl/core/stt_port_checker.sv
dv/tb_smalltalk_style_tokenizer.sv
